@@ sv/hpf_pkg.sv @@
// ----------------------------------------------------------------------------
// hpf_pkg: shared constants and a helper for the Hernquist potential block
// Widths of the root and divide cells and the saturating result encoder.
// ----------------------------------------------------------------------------
package hpf_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned WORD_W    = 32;

  // Square root chain: 64-bit radicand, one result bit per cell
  localparam int unsigned SQ_W     = 64;
  localparam int unsigned SQ_CELLS = 32;

  // Divide chain: 96-bit dividend, divisor pre-shifted by the quotient width
  localparam int unsigned DV_REM_W = 96;
  localparam int unsigned DV_DIV_W = 130;
  localparam int unsigned DV_CELLS = 32;

  // Configuration register indexes
  localparam logic REG_MASS  = 1'b0;
  localparam logic REG_SCALE = 1'b1;

  // Encode a quotient magnitude as signed Q16.16, saturating on overflow
  function automatic logic [WORD_W-1:0] enc_sat(input logic neg, input logic sat,
                                                 input logic [WORD_W-1:0] q);
    logic [WORD_W-1:0] res;
    if (neg) begin
      if (sat || (q > 32'h8000_0000)) res = 32'h8000_0000;
      else res = 32'd0 - q;
    end else begin
      if (sat || q[WORD_W-1]) res = 32'h7FFF_FFFF;
      else res = q;
    end
    return res;
  endfunction

endpackage

@@ sv/hpf_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// hpf_sqrt_cell: one step of the integer square root chain
// Resolves one root bit and hands remainder, partial root and trial bit on.
// ----------------------------------------------------------------------------
module hpf_sqrt_cell
  import hpf_pkg::*;
(
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [SQ_W-1:0] v_i,
  input  logic [SQ_W-1:0] res_i,
  input  logic [SQ_W-1:0] bit_i,
  output logic [SQ_W-1:0] v_o,
  output logic [SQ_W-1:0] res_o,
  output logic [SQ_W-1:0] bit_o
);

  logic [SQ_W:0]   trial;
  logic            ge;
  logic [SQ_W-1:0] v_d, res_d, bit_d;
  logic [SQ_W-1:0] v_q, res_q, bit_q;

  // Trial subtract of partial root plus current bit
  always_comb begin
    trial = {1'b0, res_i} + {1'b0, bit_i};
    ge    = ({1'b0, v_i} >= trial);
    v_d   = ge ? (v_i - trial[SQ_W-1:0]) : v_i;
    res_d = ge ? ((res_i >> 1) + bit_i) : (res_i >> 1);
    bit_d = bit_i >> 2;
  end

  // Advance to the neighbor
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q   <= v_d;
      res_q <= res_d;
      bit_q <= bit_d;
    end
  end

  assign v_o   = v_q;
  assign res_o = res_q;
  assign bit_o = bit_q;

endmodule

@@ sv/hpf_div_cell.sv @@
// ----------------------------------------------------------------------------
// hpf_div_cell: one step of the restoring divide chain
// Halves the shifted divisor, resolves one quotient bit, passes all on.
// ----------------------------------------------------------------------------
module hpf_div_cell
  import hpf_pkg::*;
(
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [DV_REM_W-1:0] rem_i,
  input  logic [DV_DIV_W-1:0] dsh_i,
  input  logic [WORD_W-1:0]   q_i,
  output logic [DV_REM_W-1:0] rem_o,
  output logic [DV_DIV_W-1:0] dsh_o,
  output logic [WORD_W-1:0]   q_o
);

  logic [DV_DIV_W-1:0] d;
  logic                ge;
  logic [DV_REM_W-1:0] rem_d, rem_q;
  logic [DV_DIV_W-1:0] dsh_q;
  logic [WORD_W-1:0]   q_d, q_q;

  // Compare and subtract at this bit weight
  always_comb begin
    d     = dsh_i >> 1;
    ge    = ({{(DV_DIV_W-DV_REM_W){1'b0}}, rem_i} >= d);
    rem_d = ge ? (rem_i - d[DV_REM_W-1:0]) : rem_i;
    q_d   = {q_i[WORD_W-2:0], ge};
  end

  // Advance to the neighbor
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      dsh_q <= d;
      q_q   <= q_d;
    end
  end

  assign rem_o = rem_q;
  assign dsh_o = dsh_q;
  assign q_o   = q_q;

endmodule

@@ sv/hernquist_potential_force.sv @@
// ----------------------------------------------------------------------------
// hernquist_potential_force: Hernquist potential and acceleration
// Square root chain, divisor build and four parallel divide chains.
// ----------------------------------------------------------------------------
// The block takes one position request per clock while the output is taken
// and presents potential and acceleration once the request has passed 71
// register stages, the first of them loaded at the accepting edge: two to
// form the squared radius, 32 cells of the square root chain, four to build
// r+a and (r+a)^2*r, 32 cells of the divide chains (potential and three axes
// side by side) and the output register. A stalled output holds the whole
// pipeline. Mass and scale length must be written through the register port
// only while no request is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module hernquist_potential_force
  import hpf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         dim_count_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] potential_o,
  output logic signed [31:0] acc_x_o,
  output logic signed [31:0] acc_y_o,
  output logic signed [31:0] acc_z_o
);

  localparam int unsigned ST_SQ  = 2;
  localparam int unsigned ST_S   = ST_SQ + SQ_CELLS;
  localparam int unsigned ST_DV  = ST_S + 4;
  localparam int unsigned NST    = ST_DV + DV_CELLS;
  localparam int unsigned NLANES = 4;

  typedef struct packed {
    logic [2:0][WORD_W-1:0] mag;
    logic [2:0]             neg;
    logic [2:0]             mzero;
  } meta_t;

  logic              en;
  logic [31:0]       mass_q, scale_q;
  logic [NST-1:0]    vld_q;
  meta_t             meta_q [NST];
  meta_t             meta_d;
  logic [SQ_W-1:0]   r2_q;

  logic [SQ_W-1:0]   sq_v   [SQ_CELLS+1];
  logic [SQ_W-1:0]   sq_res [SQ_CELLS+1];
  logic [SQ_W-1:0]   sq_bit [SQ_CELLS+1];

  logic [31:0]       r34_q, r35_q;
  logic [32:0]       s34_q, s35_q, s36_q, s37_q;
  logic [63:0]       x34_q [3];
  logic [63:0]       x35_q [3];
  logic [63:0]       x36_q [3];
  logic [63:0]       x37_q [3];
  logic [65:0]       ss_q;
  logic [64:0]       pplo_q, pphi_q;
  logic [97:0]       dd_q;
  logic [97:0]       dd_sum;

  logic [DV_REM_W-1:0] dv_rem [NLANES][DV_CELLS+1];
  logic [DV_DIV_W-1:0] dv_dsh [NLANES][DV_CELLS+1];
  logic [WORD_W-1:0]   dv_q   [NLANES][DV_CELLS+1];
  logic [NLANES-1:0]   sat;

  logic              out_valid_q;
  logic [31:0]       pot_q, accx_q, accy_q, accz_q;
  logic [31:0]       pot_d, accx_d, accy_d, accz_d;

  // Hold the whole pipe while a finished result is stalled
  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mass_q  <= 32'h0001_0000;
      scale_q <= 32'h0001_0000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MASS:  mass_q  <= cfg_wdata_i;
        REG_SCALE: scale_q <= cfg_wdata_i;
        default:   mass_q  <= mass_q;
      endcase
    end
  end

  // Take magnitudes and signs of the coordinates in use
  always_comb begin
    logic [31:0] p [3];
    logic [2:0]  used;
    p[0] = pos_x_i;
    p[1] = pos_y_i;
    p[2] = pos_z_i;
    used = {dim_count_i == 2'd3, dim_count_i >= 2'd2, dim_count_i >= 2'd1};
    for (int i = 0; i < 3; i++) begin
      meta_d.neg[i]   = used[i] && p[i][31];
      meta_d.mag[i]   = !used[i] ? 32'd0 : (p[i][31] ? (32'd0 - p[i]) : p[i]);
      meta_d.mzero[i] = (meta_d.mag[i] == 32'd0);
    end
  end

  // Valid and side data shift line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      meta_q[0] <= meta_d;
      for (int k = 1; k < NST; k++) meta_q[k] <= meta_q[k-1];
    end
  end

  // Sum the squares
  always_ff @(posedge clk_i) begin
    if (en) begin
      r2_q <= 64'(meta_q[0].mag[0] * meta_q[0].mag[0])
            + 64'(meta_q[0].mag[1] * meta_q[0].mag[1])
            + 64'(meta_q[0].mag[2] * meta_q[0].mag[2]);
    end
  end

  // Square root chain
  assign sq_v[0]   = r2_q;
  assign sq_res[0] = '0;
  assign sq_bit[0] = 64'h4000_0000_0000_0000;

  for (genvar k = 0; k < SQ_CELLS; k++) begin : g_sq
    hpf_sqrt_cell u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .v_i   (sq_v[k]),
      .res_i (sq_res[k]),
      .bit_i (sq_bit[k]),
      .v_o   (sq_v[k+1]),
      .res_o (sq_res[k+1]),
      .bit_o (sq_bit[k+1])
    );
  end

  // Build r+a, the numerators and the divisor (r+a)^2*r
  assign dd_sum = 98'({pphi_q, 33'd0}) + 98'(pplo_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      r34_q <= sq_res[SQ_CELLS][31:0];
      s34_q <= {1'b0, sq_res[SQ_CELLS][31:0]} + {1'b0, scale_q};
      for (int i = 0; i < 3; i++) x34_q[i] <= meta_q[ST_S-1].mag[i] * mass_q;
      ss_q   <= s34_q * s34_q;
      r35_q  <= r34_q;
      s35_q  <= s34_q;
      x35_q  <= x34_q;
      pplo_q <= ss_q[32:0] * r35_q;
      pphi_q <= ss_q[65:33] * r35_q;
      s36_q  <= s35_q;
      x36_q  <= x35_q;
      dd_q   <= dd_sum;
      s37_q  <= s36_q;
      x37_q  <= x36_q;
    end
  end

  // Divide chains: lane 0 is the potential, lanes 1 to 3 the axes
  assign dv_rem[0][0] = {48'd0, mass_q, 16'd0};
  assign dv_dsh[0][0] = {65'd0, s37_q, 32'd0};
  assign dv_q[0][0]   = '0;

  for (genvar l = 1; l < NLANES; l++) begin : g_lane_in
    assign dv_rem[l][0] = {x37_q[l-1], 32'd0};
    assign dv_dsh[l][0] = {dd_q, 32'd0};
    assign dv_q[l][0]   = '0;
  end

  for (genvar l = 0; l < NLANES; l++) begin : g_lane
    for (genvar k = 0; k < DV_CELLS; k++) begin : g_dv
      hpf_div_cell u_cell (
        .clk_i (clk_i),
        .en_i  (en),
        .rem_i (dv_rem[l][k]),
        .dsh_i (dv_dsh[l][k]),
        .q_i   (dv_q[l][k]),
        .rem_o (dv_rem[l][k+1]),
        .dsh_o (dv_dsh[l][k+1]),
        .q_o   (dv_q[l][k+1])
      );
    end
    // Remainder still at or above the divisor means the quotient overflowed
    assign sat[l] = ({34'd0, dv_rem[l][DV_CELLS]} >= dv_dsh[l][DV_CELLS]);
  end

  // Encode and saturate
  always_comb begin
    meta_t m;
    m      = meta_q[NST-1];
    pot_d  = (mass_q == 32'd0) ? 32'd0 : enc_sat(1'b1, sat[0], dv_q[0][DV_CELLS]);
    accx_d = (m.mzero[0] || mass_q == 32'd0) ? 32'd0
           : enc_sat(!m.neg[0], sat[1], dv_q[1][DV_CELLS]);
    accy_d = (m.mzero[1] || mass_q == 32'd0) ? 32'd0
           : enc_sat(!m.neg[1], sat[2], dv_q[2][DV_CELLS]);
    accz_d = (m.mzero[2] || mass_q == 32'd0) ? 32'd0
           : enc_sat(!m.neg[2], sat[3], dv_q[3][DV_CELLS]);
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vld_q[NST-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && vld_q[NST-1]) begin
      pot_q  <= pot_d;
      accx_q <= accx_d;
      accy_q <= accy_d;
      accz_q <= accz_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign potential_o = pot_q;
  assign acc_x_o     = accx_q;
  assign acc_y_o     = accy_q;
  assign acc_z_o     = accz_q;

  // The potential is never positive
  a_pot_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (potential_o[31] || potential_o == 32'd0))
    else $error("positive potential");

  // The last stage reaches the output register when the pipe advances
  a_last_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[NST-1] && en) |=> out_valid_o)
    else $error("result lost at output register");

  // A mass write lands in the register
  a_mass_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && cfg_idx_i == REG_MASS) |=> (mass_q == $past(cfg_wdata_i)))
    else $error("mass write not taken");

endmodule
